// ===== sv/acp_pkg.sv =====
// ---------------------------------------------------------------------------
// acp_pkg: shared types and helpers for the console escape parser
// Operation codes, queue word layout, number scanner and color palette.
// ---------------------------------------------------------------------------
package acp_pkg;

  localparam int SEQ_MAX_DEF = 14;
  localparam int STORE_DEPTH = 15;    // largest code length allowed
  localparam int MAX_RESULTS = 15;
  localparam logic [11:0] NUM_SAT = 12'd4095;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B; // '['
  localparam logic [7:0] CH_SEMI = 8'h3B; // ';'
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_J    = 8'h4A;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MIN  = 8'h2D;
  localparam logic [7:0] TERM_LO = 8'h40;

  localparam logic [3:0] FG_RST = 4'h7;
  localparam logic [3:0] BG_RST = 4'h0;

  localparam logic [1:0] EV_CHAR   = 2'd0;
  localparam logic [1:0] EV_CLEAR  = 2'd1;
  localparam logic [1:0] EV_CURSOR = 2'd2;

  typedef enum logic [2:0] {
    OP_CHAR, OP_CLEAR, OP_CURSOR, OP_FG, OP_BG, OP_CRESET, OP_REPLAY
  } op_t;

  typedef enum logic [1:0] {PH_WS, PH_DIG, PH_DONE} ph_t;

  typedef enum logic {ST_IDLE, ST_REPLAY} bst_t;

  typedef struct packed {
    ph_t         ph;
    logic        neg;
    logic [11:0] val;
  } num_t;

  localparam num_t NUM_INIT = '{ph: PH_WS, neg: 1'b0, val: 12'd0};

  typedef struct packed {
    op_t                          op;
    logic [7:0]                   ch;   // char, or new color for OP_FG/OP_BG
    logic signed [12:0]           x;
    logic signed [12:0]           y;
    logic [3:0]                   len;
    logic [STORE_DEPTH-1:0][7:0]  seq;
  } qword_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // one byte of an atoi-style scan, magnitude saturating
  function automatic num_t num_step(num_t p, logic [7:0] b);
    num_t        r;
    logic [15:0] prod;
    logic [3:0]  d;
    r    = p;
    d    = b[3:0];
    prod = {4'b0, p.val} * 16'd10 + {12'b0, d};
    unique case (p.ph)
      PH_WS: begin
        if (is_space(b)) begin
          r.ph = PH_WS;
        end else if (b == CH_PLUS || b == CH_MIN) begin
          r.neg = (b == CH_MIN);
          r.ph  = PH_DIG;
        end else if (is_digit(b)) begin
          r.val = {8'b0, d};
          r.ph  = PH_DIG;
        end else begin
          r.ph = PH_DONE;
        end
      end
      PH_DIG: begin
        if (is_digit(b)) begin
          r.val = (prod > {4'b0, NUM_SAT}) ? NUM_SAT : prod[11:0];
        end else begin
          r.ph = PH_DONE;
        end
      end
      PH_DONE: r = p;
      default: r = p;
    endcase
    return r;
  endfunction

  function automatic logic signed [12:0] num_value(num_t p);
    logic signed [12:0] m;
    m = $signed({1'b0, p.val});
    return p.neg ? -m : m;
  endfunction

  function automatic logic [2:0] palette(logic [2:0] i);
    logic [2:0] r;
    unique case (i)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      3'd7: r = 3'd7;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/acp_fifo.sv =====
// ---------------------------------------------------------------------------
// acp_fifo: two-word queue between front and back
// Register based; write and read may happen in the same cycle.
// ---------------------------------------------------------------------------
module acp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  acp_pkg::qword_t wdata,
  input  logic           rd,
  output acp_pkg::qword_t rdata,
  output logic           valid,
  output logic           full
);

  acp_pkg::qword_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r, cnt_nxt;

  assign valid = (cnt_r != 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign rdata = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== sv/acp_front.sv =====
// ---------------------------------------------------------------------------
// acp_front: byte intake and escape code classification
// Collects code bytes, scans numbers on the fly, queues at most one operation word per byte.
// ---------------------------------------------------------------------------
module acp_front #(
  parameter int SEQ_MAX = acp_pkg::SEQ_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,     // byte accepted this cycle
  input  logic [7:0]      in_byte,
  output logic            q_wr,
  output acp_pkg::qword_t q_wdata
);

  logic                                 in_esc_r, in_esc_nxt;
  logic [3:0]                           cnt_r, cnt_nxt;
  logic                                 semi_r, semi_nxt;
  acp_pkg::num_t                        p1_r, p1_nxt, p2_r, p2_nxt;
  logic [acp_pkg::STORE_DEPTH-1:0][7:0] store_r, seq_cur;

  logic [3:0]         len;
  logic               term;
  logic [7:0]         b0, b1;
  logic [11:0]        cv, off;
  logic signed [12:0] xv, yv;

  always_comb begin
    seq_cur          = store_r;
    seq_cur[cnt_r]   = in_byte;
    len              = cnt_r + 4'd1;
    term             = ((in_byte >= acp_pkg::TERM_LO) && (in_byte != acp_pkg::CH_LBR)) ||
                       ({28'd0, len} >= SEQ_MAX);
    b0 = seq_cur[0];
    b1 = seq_cur[1];

    p1_nxt   = (cnt_r == 4'd0) ? acp_pkg::NUM_INIT : acp_pkg::num_step(p1_r, in_byte);
    semi_nxt = semi_r;
    p2_nxt   = p2_r;
    if (cnt_r != 4'd0 && !semi_r && in_byte == acp_pkg::CH_SEMI) begin
      semi_nxt = 1'b1;
      p2_nxt   = acp_pkg::NUM_INIT;
    end else if (semi_r) begin
      p2_nxt = acp_pkg::num_step(p2_r, in_byte);
    end

    cv  = p1_nxt.val;
    off = 12'd0;
    xv  = acp_pkg::num_value(p2_nxt) - 13'sd1;
    yv  = acp_pkg::num_value(p1_nxt) - 13'sd1;

    q_wr          = 1'b0;
    q_wdata.op    = acp_pkg::OP_CHAR;
    q_wdata.ch    = in_byte;
    q_wdata.x     = '0;
    q_wdata.y     = '0;
    q_wdata.len   = len;
    q_wdata.seq   = seq_cur;
    in_esc_nxt    = in_esc_r;
    cnt_nxt       = cnt_r;

    if (take) begin
      if (!in_esc_r) begin
        if (in_byte == acp_pkg::CH_ESC) begin
          in_esc_nxt = 1'b1;
          cnt_nxt    = 4'd0;
        end else begin
          q_wr = 1'b1;
        end
      end else if (!term) begin
        cnt_nxt = len;
      end else begin
        in_esc_nxt = 1'b0;
        cnt_nxt    = 4'd0;
        if (b0 == acp_pkg::CH_LBR) begin
          q_wr       = 1'b1;
          q_wdata.op = acp_pkg::OP_REPLAY;
          if (len == 4'd3 && b1 == acp_pkg::CH_2 && in_byte == acp_pkg::CH_J) begin
            q_wdata.op = acp_pkg::OP_CLEAR;
          end else if (len == 4'd3 && b1 == acp_pkg::CH_0 && in_byte == acp_pkg::CH_M) begin
            q_wdata.op = acp_pkg::OP_CRESET;
          end else if (len >= 4'd4 && in_byte == acp_pkg::CH_M) begin
            q_wr = 1'b0;
            if (!p1_nxt.neg || cv == 12'd0) begin
              priority if (cv >= 12'd30 && cv <= 12'd37) begin
                off = cv - 12'd30; q_wr = 1'b1; q_wdata.op = acp_pkg::OP_FG;
                q_wdata.ch = {5'd0, acp_pkg::palette(off[2:0])};
              end else if (cv >= 12'd40 && cv <= 12'd47) begin
                off = cv - 12'd40; q_wr = 1'b1; q_wdata.op = acp_pkg::OP_BG;
                q_wdata.ch = {5'd0, acp_pkg::palette(off[2:0])};
              end else if (cv >= 12'd90 && cv <= 12'd97) begin
                off = cv - 12'd90; q_wr = 1'b1; q_wdata.op = acp_pkg::OP_FG;
                q_wdata.ch = {5'd1, acp_pkg::palette(off[2:0])};
              end else if (cv >= 12'd100 && cv <= 12'd107) begin
                off = cv - 12'd100; q_wr = 1'b1; q_wdata.op = acp_pkg::OP_BG;
                q_wdata.ch = {5'd1, acp_pkg::palette(off[2:0])};
              end else begin
                q_wr = 1'b0;
              end
            end
          end else if (len >= 4'd4 && in_byte == acp_pkg::CH_H) begin
            // needs a ';' that is not the last byte
            q_wr       = semi_r;
            q_wdata.op = acp_pkg::OP_CURSOR;
            q_wdata.x  = xv;
            q_wdata.y  = yv;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_esc_r <= 1'b0;
      cnt_r    <= 4'd0;
      semi_r   <= 1'b0;
      p1_r     <= acp_pkg::NUM_INIT;
      p2_r     <= acp_pkg::NUM_INIT;
    end else begin
      in_esc_r <= in_esc_nxt;
      cnt_r    <= cnt_nxt;
      if (take) begin
        if (!in_esc_r || term) begin
          semi_r <= 1'b0;
          p1_r   <= acp_pkg::NUM_INIT;
          p2_r   <= acp_pkg::NUM_INIT;
        end else begin
          semi_r <= semi_nxt;
          p1_r   <= p1_nxt;
          p2_r   <= p2_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_esc_r) store_r[cnt_r] <= in_byte;
  end

endmodule

// ===== sv/acp_back.sv =====
// ---------------------------------------------------------------------------
// acp_back: operation execution and result output register
// Holds the colors, replays unknown codes one word per cycle while the output register advances.
// ---------------------------------------------------------------------------
module acp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  acp_pkg::qword_t    q_rdata,
  output logic               q_rd,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [1:0]         out_event_kind,
  output logic [7:0]         out_char_code,
  output logic [3:0]         out_fg_color,
  output logic [3:0]         out_bg_color,
  output logic signed [12:0] out_cursor_x,
  output logic signed [12:0] out_cursor_y,
  output logic               out_last
);

  acp_pkg::bst_t st_r, st_nxt;
  logic          vld_r, vld_nxt;
  logic [3:0]    fg_r, fg_nxt, bg_r, bg_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [3:0]    tot_m1;   // index of final replay word
  logic          adv, ld, ld_last;
  logic [1:0]    ld_kind;
  logic [7:0]    ld_ch;
  logic [3:0]    rd_idx;

  assign adv    = !vld_r || out_pop;
  assign tot_m1 = (q_rdata.len == 4'd15) ? 4'd14 : q_rdata.len;
  assign rd_idx = idx_r - 4'd1;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      acp_pkg::ST_IDLE:
        if (q_valid && adv && q_rdata.op == acp_pkg::OP_REPLAY) st_nxt = acp_pkg::ST_REPLAY;
      acp_pkg::ST_REPLAY:
        if (adv && idx_r == tot_m1) st_nxt = acp_pkg::ST_IDLE;
      default: st_nxt = acp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_rd    = 1'b0;
    ld      = 1'b0;
    ld_last = 1'b1;
    ld_kind = acp_pkg::EV_CHAR;
    ld_ch   = 8'd0;
    fg_nxt  = fg_r;
    bg_nxt  = bg_r;
    idx_nxt = idx_r;
    unique case (st_r)
      acp_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_rdata.op)
            acp_pkg::OP_FG:     begin fg_nxt = q_rdata.ch[3:0]; q_rd = 1'b1; end
            acp_pkg::OP_BG:     begin bg_nxt = q_rdata.ch[3:0]; q_rd = 1'b1; end
            acp_pkg::OP_CRESET: begin
              fg_nxt = acp_pkg::FG_RST; bg_nxt = acp_pkg::BG_RST; q_rd = 1'b1;
            end
            acp_pkg::OP_CHAR: begin
              ld = adv; q_rd = adv; ld_ch = q_rdata.ch;
            end
            acp_pkg::OP_CLEAR: begin
              ld = adv; q_rd = adv; ld_kind = acp_pkg::EV_CLEAR;
            end
            acp_pkg::OP_CURSOR: begin
              ld = adv; q_rd = adv; ld_kind = acp_pkg::EV_CURSOR;
            end
            acp_pkg::OP_REPLAY: begin
              ld = adv; ld_last = 1'b0; ld_ch = acp_pkg::CH_ESC;
              if (adv) idx_nxt = 4'd1;
            end
            default: q_rd = 1'b1;
          endcase
        end
      end
      acp_pkg::ST_REPLAY: begin
        ld      = adv;
        ld_ch   = q_rdata.seq[rd_idx];
        ld_last = (idx_r == tot_m1);
        if (adv) begin
          idx_nxt = idx_r + 4'd1;
          q_rd    = ld_last;
        end
      end
      default: ;
    endcase
    vld_nxt = ld ? 1'b1 : (vld_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= acp_pkg::ST_IDLE;
      vld_r <= 1'b0;
      fg_r  <= acp_pkg::FG_RST;
      bg_r  <= acp_pkg::BG_RST;
      idx_r <= 4'd0;
    end else begin
      st_r  <= st_nxt;
      vld_r <= vld_nxt;
      fg_r  <= fg_nxt;
      bg_r  <= bg_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_event_kind <= ld_kind;
      out_char_code  <= ld_ch;
      out_fg_color   <= fg_r;
      out_bg_color   <= bg_r;
      out_cursor_x   <= (ld_kind == acp_pkg::EV_CURSOR) ? q_rdata.x : 13'sd0;
      out_cursor_y   <= (ld_kind == acp_pkg::EV_CURSOR) ? q_rdata.y : 13'sd0;
      out_last       <= ld_last;
    end
  end

  assign out_empty = !vld_r;

  a_replay_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == acp_pkg::ST_REPLAY |-> q_valid)
    else $error("replay without queued word");
  a_replay_idx: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == acp_pkg::ST_REPLAY |-> idx_r != 4'd0 && idx_r <= tot_m1)
    else $error("replay index out of range");
  a_no_pop_mid_replay: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd && st_r == acp_pkg::ST_IDLE |-> q_rdata.op != acp_pkg::OP_REPLAY)
    else $error("replay word dropped early");

endmodule

// ===== sv/ansi_escape_console_parser_top.sv =====
// ---------------------------------------------------------------------------
// ansi_escape_console_parser_top: console byte stream to display events
// Front classifies bytes and escape codes, back emits events in order.
// ---------------------------------------------------------------------------
// Usage:
//   Input is a queue write port: drive in_byte and raise in_push; the word is
//   taken on a clock edge where in_full is low. Results form a queue read
//   port: while out_empty is low the oldest event sits on the out_ ports and
//   out_pop takes it. out_last marks the final event caused by one byte.
//   Path: a plain byte's event passes through the queue and the output
//   register to the out_ ports; code bytes only collect and the terminating
//   byte sends the code's event the same way. Throughput: one byte per cycle
//   into a two-word queue while in_full is low; the back end emits one event
//   per cycle while out_pop keeps up, so a replayed unknown code of length L
//   holds the back end for min(L+1,15) events and the queue then fills and
//   raises in_full. Color codes retire in the back end with no event.
//   Reset (rst_n low, synchronous) empties the queue and the output register,
//   drops any partial code and sets foreground 7 and background 0.
//   A stalled receiver simply holds the output register; the queue absorbs
//   two more operations before in_full rises.
// ---------------------------------------------------------------------------
module ansi_escape_console_parser_top #(
  parameter int SEQ_MAX = acp_pkg::SEQ_MAX_DEF   // code length cap, 4..15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_byte,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [1:0]         out_event_kind,
  output logic [7:0]         out_char_code,
  output logic [3:0]         out_fg_color,
  output logic [3:0]         out_bg_color,
  output logic signed [12:0] out_cursor_x,
  output logic signed [12:0] out_cursor_y,
  output logic               out_last
);

  logic            take;
  logic            q_wr, q_rd, q_valid;
  acp_pkg::qword_t q_wdata, q_rdata;

  // a byte is taken only with a free queue slot, so a push never overflows
  assign take = in_push && !in_full;

  acp_front #(.SEQ_MAX(SEQ_MAX)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_byte),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  acp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .valid (q_valid),
    .full  (in_full)
  );

  acp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_rdata        (q_rdata),
    .q_rd           (q_rd),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_event_kind (out_event_kind),
    .out_char_code  (out_char_code),
    .out_fg_color   (out_fg_color),
    .out_bg_color   (out_bg_color),
    .out_cursor_x   (out_cursor_x),
    .out_cursor_y   (out_cursor_y),
    .out_last       (out_last)
  );

  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_event_kind != 2'd3)
    else $error("bad event kind");
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_event_kind != acp_pkg::EV_CHAR |-> out_char_code == 8'd0)
    else $error("char code on non-print event");
  a_xy_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_event_kind != acp_pkg::EV_CURSOR |->
      out_cursor_x == 13'sd0 && out_cursor_y == 13'sd0)
    else $error("cursor on non-cursor event");

endmodule

// ===== verif/ansi_escape_console_parser_top_test.sv =====
// ---------------------------------------------------------------------------
// ansi_escape_console_parser_top_test: event check of the escape parser
// Sends console bytes through the input queue port, predicts the display
// events of each byte and compares every popped word field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ansi_escape_console_parser_top_test;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         ch;
    logic [3:0]         fg;
    logic [3:0]         bg;
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic               last;
  } evt_t;

  localparam int SEQ_CAP = acp_pkg::SEQ_MAX_DEF;
  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic out_pop = 1'b0;
  logic in_full, out_empty, out_last;
  logic [1:0] out_event_kind;
  logic [7:0] out_char_code;
  logic [3:0] out_fg_color, out_bg_color;
  logic signed [12:0] out_cursor_x, out_cursor_y;

  ansi_escape_console_parser_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_byte(in_byte),
    .out_pop(out_pop), .out_empty(out_empty),
    .out_event_kind(out_event_kind), .out_char_code(out_char_code),
    .out_fg_color(out_fg_color), .out_bg_color(out_bg_color),
    .out_cursor_x(out_cursor_x), .out_cursor_y(out_cursor_y),
    .out_last(out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic       esc_open;
  int         code_len;
  logic [7:0] code_buf [16];
  logic [3:0] cur_fg, cur_bg;

  evt_t pending_events[$];
  int   err_count = 0;
  int   cycle_count = 0;
  bit   hold_off = 1'b0;   // receiver stall for the fill-up test

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_count++;
  endtask

  function automatic void add_event(logic [1:0] k, logic [7:0] c,
                                    int xv, int yv);
    evt_t e;
    if (pending_events.size() >= 1000000) return;
    e.kind = k; e.ch = c; e.fg = cur_fg; e.bg = cur_bg;
    e.x = xv[12:0]; e.y = yv[12:0]; e.last = 1'b0;
    pending_events.push_back(e);
  endfunction

  // atoi over code_buf[pos..code_len), magnitude capped at 4095
  function automatic int scan_num(int pos);
    int v;
    bit neg;
    v = 0; neg = 0;
    while (pos < code_len && (code_buf[pos] == 8'h20 ||
           (code_buf[pos] >= 8'h09 && code_buf[pos] <= 8'h0D))) pos++;
    if (pos < code_len && (code_buf[pos] == acp_pkg::CH_PLUS ||
                           code_buf[pos] == acp_pkg::CH_MIN)) begin
      neg = (code_buf[pos] == acp_pkg::CH_MIN);
      pos++;
    end
    while (pos < code_len && code_buf[pos] >= 8'h30 && code_buf[pos] <= 8'h39) begin
      v = v * 10 + (code_buf[pos] - 8'h30);
      if (v > 4095) v = 4095;
      pos++;
    end
    return neg ? -v : v;
  endfunction

  function automatic logic [3:0] hue(int i);
    logic [2:0] p [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
    return {1'b0, p[i]};
  endfunction

  // interprets a finished code; returns number of events queued
  function automatic int decode_code();
    int col, yv, xv, idx, n;
    logic [7:0] fin;
    fin = code_buf[code_len - 1];
    if (code_buf[0] != acp_pkg::CH_LBR) return 0;
    if (code_len == 3 && code_buf[1] == acp_pkg::CH_2 && code_buf[2] == acp_pkg::CH_J) begin
      add_event(acp_pkg::EV_CLEAR, 8'h00, 0, 0);
      return 1;
    end
    if (code_len == 3 && code_buf[1] == acp_pkg::CH_0 && code_buf[2] == acp_pkg::CH_M) begin
      cur_fg = acp_pkg::FG_RST; cur_bg = acp_pkg::BG_RST;
      return 0;
    end
    if (code_len >= 4 && fin == acp_pkg::CH_M) begin
      col = scan_num(1);
      if (col >= 30 && col <= 37) cur_fg = hue(col - 30);
      else if (col >= 40 && col <= 47) cur_bg = hue(col - 40);
      else if (col >= 90 && col <= 97) cur_fg = hue(col - 90) + 4'd8;
      else if (col >= 100 && col <= 107) cur_bg = hue(col - 100) + 4'd8;
      return 0;
    end
    if (code_len >= 4 && fin == acp_pkg::CH_H) begin
      yv = scan_num(1);
      idx = 1;
      while (idx < code_len && code_buf[idx] != acp_pkg::CH_SEMI) idx++;
      if (idx + 1 < code_len) begin
        xv = scan_num(idx + 1);
        add_event(acp_pkg::EV_CURSOR, 8'h00, xv - 1, yv - 1);
        return 1;
      end
      return 0;
    end
    // unknown bracket code is replayed behind its ESC, capped at 15 events
    add_event(acp_pkg::EV_CHAR, acp_pkg::CH_ESC, 0, 0);
    n = 1;
    for (int i = 0; i < code_len && n < acp_pkg::MAX_RESULTS; i++) begin
      add_event(acp_pkg::EV_CHAR, code_buf[i], 0, 0);
      n++;
    end
    return n;
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    int n;
    n = 0;
    if (esc_open) begin
      code_buf[code_len] = b;
      code_len++;
      if ((b >= acp_pkg::TERM_LO && b != acp_pkg::CH_LBR) || code_len >= SEQ_CAP) begin
        n = decode_code();
        esc_open = 1'b0;
        code_len = 0;
      end
    end else if (b == acp_pkg::CH_ESC) begin
      esc_open = 1'b1;
      code_len = 0;
    end else begin
      add_event(acp_pkg::EV_CHAR, b, 0, 0);
      n = 1;
    end
    if (n > 0) pending_events[pending_events.size() - 1].last = 1'b1;
  endfunction

  // one word into the input queue, after a random idle gap;
  // in_push stays high when the next word follows with no gap
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_byte <= b;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_byte(b);
    @(negedge clk);
  endtask

  task automatic send_str(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic send_code(string body);
    send_byte(acp_pkg::CH_ESC);
    send_str(body);
  endtask

  // receiver: random pop pattern, plus a long hold when requested
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_pop <= 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          out_pop <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end else begin
          out_pop <= 1'b1;
        end
      end
    end
  end

  // checker: compare each popped word with the oldest expected event
  always @(posedge clk) begin
    evt_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_events.size() == 0) begin
        $display("unexpected event kind %0d char %0d", out_event_kind, out_char_code);
        err_count++;
      end else begin
        e = pending_events.pop_front();
        if (out_event_kind != e.kind) report("kind", out_event_kind, e.kind);
        if (out_char_code != e.ch) report("char", out_char_code, e.ch);
        if (out_fg_color != e.fg) report("fg", out_fg_color, e.fg);
        if (out_bg_color != e.bg) report("bg", out_bg_color, e.bg);
        if (out_cursor_x != e.x) report("x", out_cursor_x, e.x);
        if (out_cursor_y != e.y) report("y", out_cursor_y, e.y);
        if (out_last != e.last) report("last", out_last, e.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---- tests ----

  task automatic test_plain_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(8'hAA);
    send_byte(8'h55);
  endtask

  task automatic test_known_codes();
    send_code("[2J");
    send_code("[94m");     // bright fg
    send_code("[107m");    // bright bg
    send_byte(8'h61);
    send_code("[0m");
    send_code("[ -12;+4095H");
    send_code("[5H");      // too short for a cursor code -> replayed
    send_code("[5;H");     // ';' just before the final byte
    send_code("[99999;0H"); // saturates
    send_code("[55m");     // unlisted color
  endtask

  task automatic test_odd_codes();
    send_code("[3K");      // length 3 unknown -> replayed
    send_code("Q");        // not bracketed -> dropped
    send_byte(acp_pkg::CH_ESC); send_byte(8'h5B); send_byte(8'h00);
    send_byte(acp_pkg::CH_ESC); send_byte(8'h7A);   // zero and ESC inside a code
    send_code("[1;2;3;4;5;6;7;"); // hits the length cap
    send_code("[\x80");    // high byte terminates
  endtask

  // mostly well-formed codes with random content, some noise
  task automatic test_random(int count);
    int sel, v;
    string s;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1: send_byte(8'($urandom_range(0, 255)));
        2: send_code($sformatf("[%0dm", $urandom_range(28, 109)));
        3: send_code($sformatf("[%0d;%0dH", int'($urandom_range(0, 5000)) - 500,
                               int'($urandom_range(0, 5000)) - 500));
        4: send_code($urandom_range(0, 1) ? "[2J" : "[0m");
        5: begin
          send_byte(acp_pkg::CH_ESC);
          send_byte(acp_pkg::CH_LBR);
          v = $urandom_range(0, 14);
          for (int k = 0; k < v; k++) send_byte(8'($urandom_range(0, 63)));
          send_byte(8'($urandom_range(64, 255)));
        end
        6: send_byte(8'(8'h20 + $urandom_range(0, 94)));
        default: begin
          s = $sformatf("[%0d;%0dm", $urandom_range(0, 120), $urandom_range(0, 9));
          send_code(s);
        end
      endcase
    end
  endtask

  // receiver stalls long while the sender keeps pushing, so in_full rises
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_code("[7;7;7;7;7;X");
        send_str("hello world");
        send_code("[abcdefghijZ");
      end
    join
  endtask

  initial begin
    int drain;
    repeat (4) @(posedge clk);
    @(negedge clk);
    esc_open = 1'b0; code_len = 0; cur_fg = acp_pkg::FG_RST; cur_bg = acp_pkg::BG_RST;
    rst_n <= 1'b1;
    test_plain_bytes();
    test_known_codes();
    test_odd_codes();
    test_backpressure();
    test_random(14);
    test_random(14);
    // close any open code so its events are flushed
    send_str("Zz");
    in_push <= 1'b0;
    drain = 0;
    while (pending_events.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (err_count == 0 && pending_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/acp_pkg.sv
sv/acp_fifo.sv
sv/acp_front.sv
sv/acp_back.sv
sv/ansi_escape_console_parser_top.sv
verif/ansi_escape_console_parser_top_test.sv
